// File: hdl/stlpq_pkg.sv
`default_nettype none

package stlpq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths
    localparam int TAG_PORT_W = 16;
    localparam int AGE_W      = 8;
    localparam int LVL_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CNT_PORT_W = 5;

    // Request codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Levels
    localparam logic [LVL_W-1:0] LVL_NONE  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_ONE   = 2'd1;
    localparam logic [LVL_W-1:0] LVL_TWO   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_THREE = 2'd3;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One held entry
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [AGE_W-1:0]    age;
        logic [LVL_W-1:0]    level;
    } t_entry;

    // Broadcast control to every cell
    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry item;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: hdl/stable_three_level_priority_queue.sv
`default_nettype none

// Channel   Handshake        Payload
// -------   --------------   -------------------------------------------------
// request   start / busy     i_opcode, i_item_tag, i_item_age, i_item_priority
// result    o_strobe         o_status, o_removed_*, o_head_*, o_count_*
//
// A request is taken at any edge with start high; busy stays low, so one
// request per cycle is sustained. The result strobes in the cycle after the
// request: the row of cells updates every slot at that same edge.
// Synchronous active-low reset empties the queue and clears the counts.
// The receiver cannot stall; each result shows for exactly one cycle.

module stable_three_level_priority_queue
    import stlpq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_opcode,
    input  wire logic [TAG_PORT_W-1:0] i_item_tag,
    input  wire logic [AGE_W-1:0]      i_item_age,
    input  wire logic [LVL_W-1:0]      i_item_priority,
    output logic                       o_strobe,
    output logic [STAT_W-1:0]          o_status,
    output logic [TAG_PORT_W-1:0]      o_removed_tag,
    output logic [AGE_W-1:0]           o_removed_age,
    output logic [LVL_W-1:0]           o_removed_priority,
    output logic                       o_head_valid,
    output logic [TAG_PORT_W-1:0]      o_head_tag,
    output logic [LVL_W-1:0]           o_head_priority,
    output logic [CNT_PORT_W-1:0]      o_count_total,
    output logic [CNT_PORT_W-1:0]      o_count_level_one,
    output logic [CNT_PORT_W-1:0]      o_count_level_two,
    output logic [CNT_PORT_W-1:0]      o_count_level_three
);

    t_cell_ctrl ctrl;
    t_entry     cell_entry    [QUEUE_DEPTH];
    logic       cell_valid    [QUEUE_DEPTH];
    logic       cell_displace [QUEUE_DEPTH];

    logic       accept;
    logic       full;
    logic       empty;
    logic [31:0] tag_in_wide;
    logic [31:0] tag_rm_wide;
    logic [31:0] tag_hd_wide;

    logic [CNT_W-1:0] r_cnt_total;
    logic [CNT_W-1:0] n_cnt_total;
    logic [CNT_W-1:0] r_cnt_lvl [3];
    logic [CNT_W-1:0] n_cnt_lvl [3];

    logic                  r_strobe;
    t_status               r_status;
    t_status               n_status;
    logic [TAG_PORT_W-1:0] r_removed_tag;
    logic [AGE_W-1:0]      r_removed_age;
    logic [LVL_W-1:0]      r_removed_priority;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = cell_valid[QUEUE_DEPTH-1];
    assign empty  = !cell_valid[0];

    // Build the broadcast item; a level of zero counts as most urgent
    assign tag_in_wide = 32'(i_item_tag);
    always_comb begin
        ctrl.item.tag   = tag_in_wide[TAG_BITS-1:0];
        ctrl.item.age   = i_item_age;
        ctrl.item.level = (i_item_priority == LVL_NONE) ? LVL_ONE : i_item_priority;
        ctrl.insert     = accept && (i_opcode == OP_INSERT) && !full;
        ctrl.remove     = accept && (i_opcode == OP_REMOVE) && !empty;
    end

    // Row of cells, head at index zero
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry left_entry;
        logic   left_valid;
        logic   left_displace;
        t_entry right_entry;
        logic   right_valid;

        if (g == 0) begin : g_head
            assign left_entry    = cell_entry[0];
            assign left_valid    = 1'b0;
            assign left_displace = 1'b0;
        end else begin : g_mid
            assign left_entry    = cell_entry[g-1];
            assign left_valid    = cell_valid[g-1];
            assign left_displace = cell_displace[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[g];
            assign right_valid = 1'b0;
        end else begin : g_body
            assign right_entry = cell_entry[g+1];
            assign right_valid = cell_valid[g+1];
        end

        stlpq_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (ctrl),
            .i_left_entry    (left_entry),
            .i_left_valid    (left_valid),
            .i_left_displace (left_displace),
            .i_right_entry   (right_entry),
            .i_right_valid   (right_valid),
            .o_entry         (cell_entry[g]),
            .o_valid         (cell_valid[g]),
            .o_displace      (cell_displace[g])
        );
    end

    // Advance counts and pick the status
    always_comb begin
        n_cnt_total = r_cnt_total;
        for (int k = 0; k < 3; k++) begin
            n_cnt_lvl[k] = r_cnt_lvl[k];
        end
        n_status = ST_DONE;
        if (ctrl.insert) begin
            n_cnt_total = r_cnt_total + 1'b1;
            case (ctrl.item.level)
                LVL_TWO:   n_cnt_lvl[1] = r_cnt_lvl[1] + 1'b1;
                LVL_THREE: n_cnt_lvl[2] = r_cnt_lvl[2] + 1'b1;
                default:   n_cnt_lvl[0] = r_cnt_lvl[0] + 1'b1;
            endcase
        end else if (ctrl.remove) begin
            n_cnt_total = r_cnt_total - 1'b1;
            case (cell_entry[0].level)
                LVL_ONE:   n_cnt_lvl[0] = r_cnt_lvl[0] - 1'b1;
                LVL_TWO:   n_cnt_lvl[1] = r_cnt_lvl[1] - 1'b1;
                LVL_THREE: n_cnt_lvl[2] = r_cnt_lvl[2] - 1'b1;
                default:   n_cnt_lvl[0] = r_cnt_lvl[0];
            endcase
        end else if (accept) begin
            n_status = (i_opcode == OP_INSERT) ? ST_FULL : ST_EMPTY;
        end
    end

    // Hold counts and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_total <= '0;
            for (int k = 0; k < 3; k++) begin
                r_cnt_lvl[k] <= '0;
            end
            r_strobe <= 1'b0;
        end else begin
            r_cnt_total <= n_cnt_total;
            for (int k = 0; k < 3; k++) begin
                r_cnt_lvl[k] <= n_cnt_lvl[k];
            end
            r_strobe <= accept;
        end
    end

    // Capture the status and the removed head on each accepted request; zero when nothing leaves
    assign tag_rm_wide = 32'(cell_entry[0].tag);
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            if (ctrl.remove) begin
                r_removed_tag      <= tag_rm_wide[TAG_PORT_W-1:0];
                r_removed_age      <= cell_entry[0].age;
                r_removed_priority <= cell_entry[0].level;
            end else begin
                r_removed_tag      <= '0;
                r_removed_age      <= '0;
                r_removed_priority <= LVL_NONE;
            end
        end
    end

    // Drive result ports; head comes straight from the first cell
    assign tag_hd_wide = 32'(cell_entry[0].tag);
    always_comb begin
        o_strobe            = r_strobe;
        o_status            = r_status;
        o_removed_tag       = r_removed_tag;
        o_removed_age       = r_removed_age;
        o_removed_priority  = r_removed_priority;
        o_head_valid        = cell_valid[0];
        o_head_tag          = cell_valid[0] ? tag_hd_wide[TAG_PORT_W-1:0] : '0;
        o_head_priority     = cell_valid[0] ? cell_entry[0].level : LVL_NONE;
        o_count_total       = CNT_PORT_W'(r_cnt_total);
        o_count_level_one   = CNT_PORT_W'(r_cnt_lvl[0]);
        o_count_level_two   = CNT_PORT_W'(r_cnt_lvl[1]);
        o_count_level_three = CNT_PORT_W'(r_cnt_lvl[2]);
    end

endmodule

`default_nettype wire

// File: hdl/stlpq_cell.sv
`default_nettype none

module stlpq_cell
    import stlpq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_entry     i_left_entry,
    input  wire logic       i_left_valid,
    input  wire logic       i_left_displace,
    input  wire t_entry     i_right_entry,
    input  wire logic       i_right_valid,
    output t_entry          o_entry,
    output logic            o_valid,
    output logic            o_displace
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;

    // This slot yields to the new item when empty or less urgent
    assign o_displace = !r_valid || (r_entry.level > i_ctrl.item.level);

    // Pick next content: shift right, take the item, or shift left
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.insert) begin
            if (i_left_displace) begin
                n_entry = i_left_entry;
                n_valid = i_left_valid;
            end else if (o_displace) begin
                n_entry = i_ctrl.item;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.remove) begin
            n_entry = i_right_entry;
            n_valid = i_right_valid;
        end
    end

    // Hold payload without reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // Clear occupancy on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

`default_nettype wire
